// File: sv/illm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illm_pkg
// Shared sizes, codes and control structs for the linked list manager.
// ----------------------------------------------------------------------------
package illm_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int COUNT_W  = SLOT_W;
  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 4;

  localparam logic [OP_W-1:0] OP_INSERT_AFTER = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE        = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_req;  // capture request fields
    logic look;      // decode, check, read links of the anchor
    logic ins_a;     // insert: take free slot, link anchor to it
    logic ins_b;     // insert: link new slot to successor
    logic ers_a;     // erase: unlink neighbours
    logic ers_b;     // erase: return slot to free chain
    logic load_out;  // load result register
  } cmd_t;

  // datapath -> controller, valid during look
  typedef struct packed {
    logic ins_ok;
    logic ers_ok;
  } sts_t;

endpackage

// File: sv/illm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illm_req_if / illm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface illm_req_if;
  logic                          valid;
  logic                          ready;
  logic [illm_pkg::OP_W-1:0]     operation;
  logic [illm_pkg::POS_W-1:0]    position;
  logic [illm_pkg::KEY_W-1:0]    key_handle;
  logic [illm_pkg::KEY_W-1:0]    key_hash;

  modport source(output valid, operation, position, key_handle, key_hash, input ready);
  modport sink(input valid, operation, position, key_handle, key_hash, output ready);
endinterface

interface illm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [illm_pkg::STATUS_W-1:0]   status;
  logic [illm_pkg::OUT_W-1:0]      slot_used;
  logic [illm_pkg::OUT_W-1:0]      element_count;
  logic [illm_pkg::OUT_W-1:0]      head_slot;
  logic [illm_pkg::OUT_W-1:0]      tail_slot;

  modport source(output valid, status, slot_used, element_count, head_slot, tail_slot,
                 input ready);
  modport sink(input valid, status, slot_used, element_count, head_slot, tail_slot,
               output ready);
endinterface

// File: sv/illm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illm_dp
// Link tables, free chain, element store and result register.
// ----------------------------------------------------------------------------
module illm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  illm_pkg::cmd_t                    cmd,
  output illm_pkg::sts_t                    sts,
  input  logic [illm_pkg::OP_W-1:0]         operation,
  input  logic [illm_pkg::POS_W-1:0]        position,
  input  logic [illm_pkg::KEY_W-1:0]        key_handle,
  input  logic [illm_pkg::KEY_W-1:0]        key_hash,
  output logic [illm_pkg::STATUS_W-1:0]     status,
  output logic [illm_pkg::OUT_W-1:0]        slot_used,
  output logic [illm_pkg::OUT_W-1:0]        element_count,
  output logic [illm_pkg::OUT_W-1:0]        head_slot,
  output logic [illm_pkg::OUT_W-1:0]        tail_slot
);

  // request capture
  logic [illm_pkg::OP_W-1:0]   op_q;
  logic [illm_pkg::POS_W-1:0]  pos_q;
  logic [illm_pkg::KEY_W-1:0]  key_q;
  logic [illm_pkg::KEY_W-1:0]  hash_q;

  // list state
  logic [illm_pkg::SLOT_W-1:0]  next_link [illm_pkg::SLOTS];
  logic [illm_pkg::SLOT_W-1:0]  prev_link [illm_pkg::SLOTS];
  logic [illm_pkg::SLOTS-1:0]   slot_free;
  logic [illm_pkg::SLOT_W-1:0]  free_head;
  logic [illm_pkg::COUNT_W-1:0] count;
  logic [illm_pkg::KEY_W-1:0]   key_store  [illm_pkg::SLOTS];
  logic [illm_pkg::KEY_W-1:0]   hash_store [illm_pkg::SLOTS];

  // per-request working registers
  logic [illm_pkg::SLOT_W-1:0]   target_q;  // anchor or slot to erase
  logic [illm_pkg::SLOT_W-1:0]   link_a_q;  // next of target
  logic [illm_pkg::SLOT_W-1:0]   link_b_q;  // prev of target
  logic [illm_pkg::SLOT_W-1:0]   used_q;
  logic [illm_pkg::STATUS_W-1:0] status_q;

  // decode
  logic [illm_pkg::SLOT_W-1:0]   anchor;
  logic                          anchor_in_range;
  logic                          anchor_used;
  logic                          is_insert;
  logic                          is_erase;
  logic [illm_pkg::SLOT_W-1:0]   next_rd_addr;
  logic [illm_pkg::SLOT_W-1:0]   next_rd;
  logic [illm_pkg::STATUS_W-1:0] status_d;
  logic                          ins_ok;
  logic                          ers_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q   <= operation;
      pos_q  <= position;
      key_q  <= key_handle;
      hash_q <= key_hash;
    end
  end

  always_comb begin
    anchor          = illm_pkg::SLOT_W'(pos_q);
    anchor_in_range = (int'(pos_q) < illm_pkg::SLOTS);
    is_insert       = 1'b0;
    is_erase        = 1'b0;
    unique case (op_q)
      illm_pkg::OP_INSERT_AFTER: begin
        is_insert = 1'b1;
      end
      illm_pkg::OP_PUSH_BACK: begin
        anchor          = prev_link[0];
        anchor_in_range = 1'b1;
        is_insert       = 1'b1;
      end
      illm_pkg::OP_PUSH_FRONT: begin
        anchor          = '0;
        anchor_in_range = 1'b1;
        is_insert       = 1'b1;
      end
      illm_pkg::OP_ERASE: begin
        is_erase = 1'b1;
      end
      illm_pkg::OP_POP_BACK: begin
        anchor          = prev_link[0];
        anchor_in_range = 1'b1;
        is_erase        = 1'b1;
      end
      default: begin
        anchor_in_range = 1'b1;
      end
    endcase
    anchor_used = anchor_in_range && !slot_free[anchor];
  end

  // single variable read port on next_link: anchor in look, free head after
  assign next_rd_addr = cmd.look ? anchor : free_head;
  assign next_rd      = next_link[next_rd_addr];

  always_comb begin
    status_d = illm_pkg::ST_OK;
    ins_ok   = 1'b0;
    ers_ok   = 1'b0;
    if (is_insert) begin
      priority if (free_head == '0) begin
        status_d = illm_pkg::ST_FULL;
      end else if (!anchor_used) begin
        status_d = illm_pkg::ST_BADPOS;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (is_erase) begin
      priority if (op_q == illm_pkg::OP_POP_BACK && count == '0) begin
        status_d = illm_pkg::ST_EMPTY;
      end else if (anchor == '0 || !anchor_used) begin
        status_d = illm_pkg::ST_BADPOS;
      end else begin
        ers_ok = 1'b1;
      end
    end
  end

  assign sts.ins_ok = ins_ok;
  assign sts.ers_ok = ers_ok;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      target_q <= anchor;
      link_a_q <= next_rd;
      link_b_q <= prev_link[anchor];
      status_q <= status_d;
      priority if (ins_ok) begin
        used_q <= free_head;
      end else if (ers_ok) begin
        used_q <= anchor;
      end else begin
        used_q <= '0;
      end
    end
  end

  // link tables and free chain: one write per table per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < illm_pkg::SLOTS; i++) begin
        next_link[illm_pkg::SLOT_W'(i)] <= (i == 0 || i + 1 >= illm_pkg::SLOTS) ? '0 :
                                           illm_pkg::SLOT_W'(i + 1);
        prev_link[illm_pkg::SLOT_W'(i)] <= '0;
        slot_free[illm_pkg::SLOT_W'(i)] <= (i != 0);
      end
      free_head <= illm_pkg::SLOT_W'(1);
      count     <= '0;
    end else begin
      if (cmd.ins_a) begin
        next_link[target_q]  <= free_head;
        prev_link[free_head] <= target_q;
        slot_free[free_head] <= 1'b0;
        free_head            <= next_rd;
        count                <= count + illm_pkg::COUNT_W'(1);
      end
      if (cmd.ins_b) begin
        next_link[used_q]   <= link_a_q;
        prev_link[link_a_q] <= used_q;
      end
      if (cmd.ers_a) begin
        next_link[link_b_q] <= link_a_q;
        prev_link[link_a_q] <= link_b_q;
      end
      if (cmd.ers_b) begin
        next_link[target_q] <= free_head;
        prev_link[target_q] <= '0;
        slot_free[target_q] <= 1'b1;
        free_head           <= target_q;
        if (count != '0) begin
          count <= count - illm_pkg::COUNT_W'(1);
        end
      end
    end
  end

  // element payload store
  always_ff @(posedge clk) begin
    if (cmd.ins_a) begin
      key_store[free_head]  <= key_q;
      hash_store[free_head] <= hash_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= status_q;
      slot_used     <= illm_pkg::OUT_W'(used_q);
      element_count <= illm_pkg::OUT_W'(count);
      head_slot     <= illm_pkg::OUT_W'(next_link[0]);
      tail_slot     <= illm_pkg::OUT_W'(prev_link[0]);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) < illm_pkg::SLOTS)
    else $error("element count beyond pool size");
`endif

endmodule

// File: sv/illm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illm_ctrl
// Request sequencer and result handshake.
// ----------------------------------------------------------------------------
module illm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  illm_pkg::sts_t sts,
  output illm_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_INS_A = 7'b0000100,
    S_INS_B = 7'b0001000,
    S_ERS_A = 7'b0010000,
    S_ERS_B = 7'b0100000,
    S_REPLY = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) || (state == S_REPLY && out_free);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load_req = accept;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        priority if (sts.ins_ok) begin
          state_next = S_INS_A;
        end else if (sts.ers_ok) begin
          state_next = S_ERS_A;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_INS_A: begin
        cmd.ins_a  = 1'b1;
        state_next = S_INS_B;
      end
      S_INS_B: begin
        cmd.ins_b  = 1'b1;
        state_next = S_REPLY;
      end
      S_ERS_A: begin
        cmd.ers_a  = 1'b1;
        state_next = S_ERS_B;
      end
      S_ERS_B: begin
        cmd.ers_b  = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = accept ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOK)
    else $error("accepted request not decoded next cycle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("pending result overwritten");
  a_insert_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_A |=> state == S_INS_B)
    else $error("insert link update split");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> rsp_valid)
    else $error("loaded result not presented");
`endif

endmodule

// File: sv/indexed_linked_list_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_linked_list_manager
// Slot-pool doubly linked list with sentinel and free chain.
// ----------------------------------------------------------------------------
// A pool of 16 slots holds one circular doubly linked list; slot 0 is the
// sentinel (its next link is the head, its prev link the tail) and unused
// slots sit on a free chain. Each request transaction inserts after a slot,
// pushes at the back or front, erases a slot or pops the back, and returns
// exactly one result transaction carrying status, slot touched, element count
// and head/tail slots. A successful insert or erase goes from acceptance
// through decode, two link-update steps and the result load, as each link
// table has one write port; a rejected or ignored request goes from decode
// straight to the result load. A new request is accepted in the cycle the
// previous result is loaded, and the result register holds a finished
// transaction while the next request is taken in.
// Rejections: an insert with no free slot reports pool full before any
// position check; inserting after a free slot, or erasing the sentinel or a
// free slot, reports a bad position; popping an empty list reports empty.
// None of these change state. Operation codes 5 to 7 report ok with slot 0.
// ----------------------------------------------------------------------------
module indexed_linked_list_manager (
  input  logic        clk,
  input  logic        rst,
  illm_req_if.sink    req,
  illm_rsp_if.source  rsp
);

  illm_pkg::cmd_t cmd;  // sequencer commands into the datapath
  illm_pkg::sts_t sts;  // decode outcome back to the sequencer

  // sequencer: owns both handshakes
  illm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: link tables, free chain and result register
  illm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (req.operation),
    .position      (req.position),
    .key_handle    (req.key_handle),
    .key_hash      (req.key_hash),
    .status        (rsp.status),
    .slot_used     (rsp.slot_used),
    .element_count (rsp.element_count),
    .head_slot     (rsp.head_slot),
    .tail_slot     (rsp.tail_slot)
  );

endmodule

// File: test/indexed_linked_list_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_linked_list_manager_test
// Self-checking testbench for the slot-pool doubly linked list manager.
// ----------------------------------------------------------------------------
// Keeps its own copy of the link tables, the free chain and the element count.
// It works out the result of each accepted request transaction and compares
// it field by field with the result transactions as they come out. A short
// directed run covers the rejections, every operation and a full pool. A long
// random run follows, mostly well-formed work on live slots, under several
// idle and stall patterns and one long result hold-off.
// ----------------------------------------------------------------------------
module indexed_linked_list_manager_test;
  import illm_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key_handle;
    logic [KEY_W-1:0] key_hash;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    slot_used;
    logic [OUT_W-1:0]    element_count;
    logic [OUT_W-1:0]    head_slot;
    logic [OUT_W-1:0]    tail_slot;
  } list_result_t;

  logic clk;
  logic rst;

  illm_req_if req_bus ();
  illm_rsp_if rsp_bus ();

  indexed_linked_list_manager u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow of the list: link tables, free flags, free chain head and count.
  logic [SLOT_W-1:0]  link_next [SLOTS];
  logic [SLOT_W-1:0]  link_prev [SLOTS];
  logic               slot_free [SLOTS];
  logic [SLOT_W-1:0]  free_top;
  logic [COUNT_W-1:0] live_count;

  list_result_t pending_results[$];

  int error_count;
  int sent_count;
  int result_count;
  int status_seen [4];
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow list
  // --------------------------------------------------------------------------
  // Post-reset layout: sentinel points at itself, slots 1..15 chained free.
  function automatic void reset_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      link_next[SLOT_W'(i)] = (i == 0 || i == SLOTS - 1) ? '0 : SLOT_W'(i + 1);
      link_prev[SLOT_W'(i)] = '0;
      slot_free[SLOT_W'(i)] = (i != 0);
    end
    free_top   = SLOT_W'(1);
    live_count = '0;
  endfunction

  // Insert after anchor. Pool full is checked first, then the anchor.
  function automatic void link_after(input logic [SLOT_W-1:0] anchor,
                                     output logic [STATUS_W-1:0] st,
                                     output logic [SLOT_W-1:0] used);
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] succ;
    used = '0;
    if (free_top == '0) begin
      st = ST_FULL;
    end else if (slot_free[anchor]) begin
      st = ST_BADPOS;
    end else begin
      slot              = free_top;
      free_top          = link_next[slot];
      slot_free[slot]   = 1'b0;
      succ              = link_next[anchor];
      link_next[slot]   = succ;
      link_prev[slot]   = anchor;
      link_next[anchor] = slot;
      link_prev[succ]   = slot;
      live_count        = live_count + 1'b1;
      st                = ST_OK;
      used              = slot;
    end
  endfunction

  // Unlink a live slot and push it on the front of the free chain.
  function automatic void unlink_slot(input logic [SLOT_W-1:0] pos,
                                      output logic [STATUS_W-1:0] st,
                                      output logic [SLOT_W-1:0] used);
    logic [SLOT_W-1:0] pred;
    logic [SLOT_W-1:0] succ;
    used = '0;
    if (pos == '0 || slot_free[pos]) begin
      st = ST_BADPOS;
    end else begin
      pred            = link_prev[pos];
      succ            = link_next[pos];
      link_next[pred] = succ;
      link_prev[succ] = pred;
      link_next[pos]  = free_top;
      link_prev[pos]  = '0;
      slot_free[pos]  = 1'b1;
      free_top        = pos;
      if (live_count != '0) live_count = live_count - 1'b1;
      st              = ST_OK;
      used            = pos;
    end
  endfunction

  // Apply one request to the shadow and return the result it should give.
  function automatic list_result_t apply_request(input request_t r);
    list_result_t      res;
    logic [STATUS_W-1:0] st;
    logic [SLOT_W-1:0]   used;
    st   = ST_OK;
    used = '0;
    case (r.operation)
      OP_INSERT_AFTER: link_after(r.position, st, used);
      OP_PUSH_BACK:    link_after(link_prev[0], st, used);
      OP_PUSH_FRONT:   link_after('0, st, used);
      OP_ERASE:        unlink_slot(r.position, st, used);
      OP_POP_BACK: begin
        if (live_count == '0) st = ST_EMPTY;
        else unlink_slot(link_prev[0], st, used);
      end
      default: ;  // codes 5..7: no effect, ok with slot 0
    endcase
    res.status        = st;
    res.slot_used     = used;
    res.element_count = live_count;
    res.head_slot     = link_next[0];
    res.tail_slot     = link_prev[0];
    return res;
  endfunction

  // Random live slot in list order; the sentinel counts only if asked for.
  function automatic logic [SLOT_W-1:0] pick_live_slot(input bit with_sentinel);
    logic [SLOT_W-1:0] s;
    int                k;
    s = '0;
    if (live_count == '0) return '0;
    k = $urandom_range(with_sentinel ? 0 : 1, int'(live_count));
    for (int i = 0; i < k; i++) s = link_next[s];
    return s;
  endfunction

  // Random free slot, or the sentinel when the pool is full.
  function automatic logic [SLOT_W-1:0] pick_free_slot();
    logic [SLOT_W-1:0] spare[$];
    for (int i = 1; i < SLOTS; i++)
      if (slot_free[SLOT_W'(i)]) spare.push_back(SLOT_W'(i));
    if (spare.size() == 0) return '0;
    return spare[$urandom_range(0, spare.size() - 1)];
  endfunction

  // Mostly well-formed traffic on live slots; fill_bias tilts towards inserts.
  function automatic request_t next_request(input bit fill_bias);
    request_t r;
    int       roll;
    int       ins_cut;
    r.key_handle = $urandom;
    r.key_hash   = $urandom;
    r.position   = POS_W'($urandom_range(0, SLOTS - 1));
    roll         = $urandom_range(0, 99);
    ins_cut      = 12 + (fill_bias ? 62 : 26);
    if (roll < 4) begin
      r.operation = OP_W'($urandom_range(5, 7));
    end else if (roll < 12) begin
      // broken request: anchor or target is a free slot (or the sentinel)
      r.operation = $urandom_range(0, 1) ? OP_ERASE : OP_INSERT_AFTER;
      r.position  = pick_free_slot();
    end else if (roll < ins_cut) begin
      case ($urandom_range(0, 2))
        0: begin
          r.operation = OP_INSERT_AFTER;
          r.position  = pick_live_slot(1'b1);
        end
        1:       r.operation = OP_PUSH_BACK;
        default: r.operation = OP_PUSH_FRONT;
      endcase
    end else if ($urandom_range(0, 2) == 0) begin
      r.operation = OP_POP_BACK;
    end else begin
      r.operation = OP_ERASE;
      r.position  = pick_live_slot(1'b0);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: called at a falling edge, returns at the falling edge after
  // the transaction. Valid is left high so back-to-back items need no toggle.
  // --------------------------------------------------------------------------
  task automatic send_request(input request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.operation  <= r.operation;
    req_bus.position   <= r.position;
    req_bus.key_handle <= r.key_handle;
    req_bus.key_hash   <= r.key_hash;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_results.push_back(apply_request(r));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] hash);
    request_t r;
    r.operation  = op;
    r.position   = pos;
    r.key_handle = key;
    r.key_hash   = hash;
    send_request(r);
  endtask

  // Stop offering, wait for every outstanding result, then idle before returning.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // Ready changes on the falling edge: random stall, or a counted hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      result_count++;
      status_seen[rsp_bus.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, got status %0d slot %0d",
                 $time, rsp_bus.status, rsp_bus.slot_used);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", int'(exp_res.status), int'(rsp_bus.status));
        check_field("slot_used", int'(exp_res.slot_used), int'(rsp_bus.slot_used));
        check_field("element_count", int'(exp_res.element_count),
                    int'(rsp_bus.element_count));
        check_field("head_slot", int'(exp_res.head_slot), int'(rsp_bus.head_slot));
        check_field("tail_slot", int'(exp_res.tail_slot), int'(rsp_bus.tail_slot));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty list: nothing to pop, nothing to erase, no live anchor but slot 0.
  task automatic test_rejections();
    issue(OP_POP_BACK,     4'd0,  32'h0, 32'h0);
    issue(OP_ERASE,        4'd0,  32'h0, 32'h0);
    issue(OP_ERASE,        4'd9,  32'h0, 32'h0);
    issue(OP_INSERT_AFTER, 4'd4,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  // Every operation at least once, with key and hash at both extremes.
  task automatic test_basic_ops();
    issue(OP_INSERT_AFTER, 4'd0, 32'h0000_0000, 32'h0000_0000);
    issue(OP_PUSH_BACK,    4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_PUSH_FRONT,   4'd15, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    issue(OP_INSERT_AFTER, 4'd2, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    issue(OP_ERASE,        4'd1, 32'h0, 32'h0);
    issue(OP_POP_BACK,     4'd0, 32'h0, 32'h0);
    drain();
  endtask

  // Undefined codes must leave the list alone.
  task automatic test_ignored_ops();
    issue(3'd5, 4'd3,  32'h1234_5678, 32'h8765_4321);
    issue(3'd6, 4'd0,  32'h0, 32'h0);
    issue(3'd7, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  // Fill every slot, check full on insert, then erase a slot and insert after it.
  task automatic test_pool_full();
    while (live_count != COUNT_W'(SLOTS - 1))
      issue(OP_PUSH_BACK, 4'd0, $urandom, $urandom);
    issue(OP_PUSH_FRONT,   4'd0,  32'h0, 32'h0);
    issue(OP_INSERT_AFTER, 4'd15, 32'h0, 32'h0);
    issue(OP_ERASE,        4'd15, 32'h0, 32'h0);
    issue(OP_INSERT_AFTER, 4'd15, 32'h0, 32'h0);
    drain();
  endtask

  // Long result hold-off while requests keep coming: the block must stall its
  // input once its result register and working request are both occupied.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_cycles = 60;
    @(negedge clk);
    repeat (16) send_request(next_request($urandom_range(0, 1)));
    drain();
  endtask

  // Random traffic; the fill bias flips at the full and empty extremes.
  task automatic test_random(input int n, input int idle_pct, input int stall);
    bit fill_bias;
    fill_bias     = 1'b1;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n) begin
      if (live_count == COUNT_W'(SLOTS - 1)) fill_bias = 1'b0;
      else if (live_count == '0) fill_bias = 1'b1;
      send_request(next_request(fill_bias));
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.operation  = '0;
    req_bus.position   = '0;
    req_bus.key_handle = '0;
    req_bus.key_hash   = '0;
    rsp_bus.ready      = 1'b0;
    error_count        = 0;
    sent_count         = 0;
    result_count       = 0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    hold_cycles        = 0;
    status_seen        = '{default: 0};
    reset_shadow();

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_rejections();
    test_basic_ops();
    test_ignored_ops();
    test_pool_full();
    test_back_pressure();
    test_random(200, 0, 0);
    test_random(200, 71, 0);
    test_random(200, 0, 71);
    test_random(200, 21, 21);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d results still expected, got none", $time, pending_results.size());
      error_count++;
    end

    $display("Covered %0d requests, %0d results: %0d ok, %0d full, %0d bad position, %0d empty",
             sent_count, result_count, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_BADPOS], status_seen[ST_EMPTY]);
    $display("Idle patterns: none, sender 71%%, receiver 71%%, both 21%%, one long hold-off");
    if (error_count == 0) begin
      $display("** indexed_linked_list_manager: PASSED **");
    end else begin
      $display("** indexed_linked_list_manager: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("** indexed_linked_list_manager: FAILED **");
    $finish;
  end

endmodule
